>>> hw/rtl/flash_page_append_log_assert.svh
// Assertion macros shared by the append log RTL.
`ifndef FLASH_PAGE_APPEND_LOG_ASSERT_SVH
`define FLASH_PAGE_APPEND_LOG_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define FPAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define FPAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fpal_pkg.sv
// Shared types, constants and helper functions of the flash page append log.
package fpal_pkg;

  localparam int unsigned PAGE_SLOTS_DEF = 512;
  localparam logic [15:0] ERASED_WORD = 16'hFFFF;
  localparam logic [15:0] MODE_MAX = 16'd2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CYCLE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Source of the working value register.
  typedef enum logic [2:0] {
    VAL_KEEP,
    VAL_ERASED,
    VAL_ZERO,
    VAL_ONE,
    VAL_LAST,
    VAL_NEXT
  } val_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHECK,
    ST_REPAIR,
    ST_APPEND,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic     capture;
    logic     rd_last;
    val_sel_t val_sel;
    logic     append;
    logic     repair;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    op_t  op;
    logic page_empty;
    logic last_ok;
    logic out_busy;
  } stat_t;

  // Next mode in the sequence 0, 1, 2, 0 for a valid current mode.
  function automatic logic [15:0] next_mode(input logic [15:0] m);
    logic [15:0] r;
    case (m)
      16'd0:   r = 16'd1;
      16'd1:   r = 16'd2;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/fpal_dp.sv
// Datapath of the append log: page memory, fill count, working value and result register.
module fpal_dp #(
  parameter int unsigned PAGE_SLOTS = fpal_pkg::PAGE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  fpal_pkg::cmd_t      cmd,
  output fpal_pkg::stat_t     stat,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata
);

  localparam int unsigned AW = $clog2(PAGE_SLOTS);
  localparam int unsigned CW = $clog2(PAGE_SLOTS + 1);

  logic [15:0]       mem [PAGE_SLOTS];

  logic [CW-1:0]     ap_r, ap_nxt;
  fpal_pkg::op_t     op_r;
  logic [15:0]       value_r, value_nxt;
  logic [15:0]       rd_data_r;
  logic              erased_r;
  logic              repaired_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;

  logic              full;
  logic [CW-1:0]     ap_base;
  logic [CW-1:0]     ap_dec;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CW+9:0]     ap_ext;

  // The fill count is the append point: slots below it hold data, the rest are erased.
  assign full    = (ap_r == CW'(PAGE_SLOTS));
  assign ap_base = full ? '0 : ap_r;
  assign wr_addr = ap_base[AW-1:0];
  assign ap_dec  = ap_r - CW'(1);
  assign rd_addr = ap_dec[AW-1:0];
  assign ap_ext  = {10'd0, ap_r};

  // Appending an erased word leaves the slot erased, so the count does not move unless the page is full.
  always_comb begin
    ap_nxt = ap_r;
    if (cmd.append) begin
      ap_nxt = ap_base + CW'(value_r != fpal_pkg::ERASED_WORD);
    end
  end

  // Working value selection.
  always_comb begin
    case (cmd.val_sel)
      fpal_pkg::VAL_ERASED: value_nxt = fpal_pkg::ERASED_WORD;
      fpal_pkg::VAL_ZERO:   value_nxt = 16'd0;
      fpal_pkg::VAL_ONE:    value_nxt = 16'd1;
      fpal_pkg::VAL_LAST:   value_nxt = rd_data_r;
      fpal_pkg::VAL_NEXT:   value_nxt = fpal_pkg::next_mode(rd_data_r);
      default:              value_nxt = value_r;
    endcase
  end

  // Page memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_addr] <= value_r;
    end
    if (cmd.rd_last) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Item registers and flags.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= fpal_pkg::op_t'(in_tuser);
      value_r    <= (fpal_pkg::op_t'(in_tuser) == fpal_pkg::OP_APPEND) ? in_tdata : 16'd0;
      erased_r   <= 1'b0;
      repaired_r <= 1'b0;
    end else begin
      value_r <= value_nxt;
      if (cmd.append && full) begin
        erased_r <= 1'b1;
      end
      if (cmd.repair) begin
        repaired_r <= 1'b1;
      end
    end
  end

  // Fill count; reset empties the page without touching the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r <= '0;
    end else begin
      ap_r <= ap_nxt;
    end
  end

  // Result register decouples the sequencer from the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {4'd0, ap_ext[9:0], repaired_r, erased_r, value_r};
    end
  end

  assign stat.op         = op_r;
  assign stat.page_empty = (ap_r == '0);
  assign stat.last_ok    = (rd_data_r <= fpal_pkg::MODE_MAX);
  assign stat.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/fpal_ctrl.sv
// Sequencer of the append log: steps each operation through read, repair and append.
module fpal_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  fpal_pkg::stat_t stat,
  output fpal_pkg::cmd_t  cmd
);

  fpal_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpal_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpal_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = fpal_pkg::ST_DISPATCH;
        end
      end
      fpal_pkg::ST_DISPATCH: begin
        unique case (stat.op)
          fpal_pkg::OP_APPEND: state_nxt = fpal_pkg::ST_APPEND;
          fpal_pkg::OP_READ:   state_nxt = stat.page_empty ? fpal_pkg::ST_DONE
                                                           : fpal_pkg::ST_CHECK;
          fpal_pkg::OP_CYCLE:  state_nxt = stat.page_empty ? fpal_pkg::ST_APPEND
                                                           : fpal_pkg::ST_CHECK;
          default:             state_nxt = fpal_pkg::ST_DONE;
        endcase
      end
      fpal_pkg::ST_CHECK: begin
        if (!stat.last_ok) begin
          state_nxt = fpal_pkg::ST_REPAIR;
        end else if (stat.op == fpal_pkg::OP_CYCLE) begin
          state_nxt = fpal_pkg::ST_APPEND;
        end else begin
          state_nxt = fpal_pkg::ST_DONE;
        end
      end
      fpal_pkg::ST_REPAIR: begin
        state_nxt = (stat.op == fpal_pkg::OP_CYCLE) ? fpal_pkg::ST_APPEND
                                                     : fpal_pkg::ST_DONE;
      end
      fpal_pkg::ST_APPEND: begin
        state_nxt = fpal_pkg::ST_DONE;
      end
      fpal_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = fpal_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpal_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    in_tready    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.rd_last  = 1'b0;
    cmd.val_sel  = fpal_pkg::VAL_KEEP;
    cmd.append   = 1'b0;
    cmd.repair   = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      fpal_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      fpal_pkg::ST_DISPATCH: begin
        unique case (stat.op)
          fpal_pkg::OP_READ: begin
            if (stat.page_empty) begin
              cmd.val_sel = fpal_pkg::VAL_ERASED;
            end else begin
              cmd.rd_last = 1'b1;
            end
          end
          fpal_pkg::OP_CYCLE: begin
            if (stat.page_empty) begin
              cmd.val_sel = fpal_pkg::VAL_ZERO;
            end else begin
              cmd.rd_last = 1'b1;
            end
          end
          default: ;
        endcase
      end
      fpal_pkg::ST_CHECK: begin
        if (!stat.last_ok) begin
          cmd.val_sel = fpal_pkg::VAL_ZERO;
          cmd.repair  = 1'b1;
        end else if (stat.op == fpal_pkg::OP_CYCLE) begin
          cmd.val_sel = fpal_pkg::VAL_NEXT;
        end else begin
          cmd.val_sel = fpal_pkg::VAL_LAST;
        end
      end
      fpal_pkg::ST_REPAIR: begin
        // Store the repair zero; a cycle then advances from mode zero.
        cmd.append = 1'b1;
        if (stat.op == fpal_pkg::OP_CYCLE) begin
          cmd.val_sel = fpal_pkg::VAL_ONE;
        end
      end
      fpal_pkg::ST_APPEND: begin
        cmd.append = 1'b1;
      end
      fpal_pkg::ST_DONE: begin
        cmd.out_load = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/flash_page_append_log.sv
// Top level of the flash page append log: sequencer, datapath and checks.
//
// One page of PAGE_SLOTS halfword slots is kept as an append log. A word on the
// input channel carries the operation in in_tuser and the data halfword in
// in_tdata; one result word comes out on the output channel for each input word.
// Append stores the data at the first erased slot, erasing the whole page first
// when it is full. Read returns the last stored mode, repairing an out-of-range
// value by appending zero. Cycle advances the mode modulo three and stores it.
// The append point is held as a fill count, so no scan of the page is needed.
// One word is in work at a time; the next is accepted the cycle after the result
// is loaded. The sequencer steps each word from dispatch through check, repair
// and append as its operation needs, to done; the page memory read is registered.
// Reset clears the fill count, which makes the page read as erased at once.
// A stalled receiver holds the result register; the block then waits before
// loading the next result, and input is taken again once that result moves.
module flash_page_append_log #(
  parameter int unsigned PAGE_SLOTS = fpal_pkg::PAGE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] data
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] value, [16] page_erased,
                                  // [17] corrupt_repaired, [27:18] slots_used, [31:28] zero
);

  `include "flash_page_append_log_assert.svh"

  fpal_pkg::cmd_t  cmd;
  fpal_pkg::stat_t stat;

  fpal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpal_dp #(
    .PAGE_SLOTS (PAGE_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Only one word is in work: an accepted word closes the input until it is done.
  `FPAL_ASSERT_NEXT(a_one_in_work, in_tvalid && in_tready, !in_tready, "second word accepted while busy")

  // A repair always yields mode zero on a read or mode one on a cycle.
  `FPAL_ASSERT_NOW(a_repair_value, out_tvalid && out_tdata[17], out_tdata[15:0] == 16'd0 || out_tdata[15:0] == 16'd1, "repair result is not mode zero or one")

  // The sequencer never appends and reads the page in the same cycle.
  `FPAL_ASSERT_NOW(a_no_rw_clash, cmd.append, !cmd.rd_last, "page read and write in one cycle")

endmodule

>>> dv/flash_page_append_log_checker.sv
// Checker for the flash page append log: keeps a page image, predicts each result word and compares.
module flash_page_append_log_checker #(
  parameter int unsigned PAGE_SLOTS = fpal_pkg::PAGE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] data
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [15:0] value, [16] page_erased,
                                  // [17] corrupt_repaired, [27:18] slots_used
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          erases_seen,
  output int          repairs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result word split into its fields.
  typedef struct packed {
    logic [15:0] value;
    logic        erased;
    logic        repaired;
    logic [9:0]  used;
  } log_result_t;

  logic [15:0] page_img [PAGE_SLOTS];
  log_result_t expected_results [$];
  log_result_t seen;
  log_result_t want;
  int fails;
  int n_results;
  int n_erases;
  int n_repairs;

  // Index of the first erased slot, or PAGE_SLOTS when the page is full.
  function automatic int unsigned fill_point();
    int unsigned i;
    i = 0;
    while (i < PAGE_SLOTS && page_img[i] != fpal_pkg::ERASED_WORD) i++;
    return i;
  endfunction

  function automatic void wipe_page();
    foreach (page_img[k]) page_img[k] = fpal_pkg::ERASED_WORD;
  endfunction

  // Writes at the append point; a full page is erased first.
  function automatic void store_word(input logic [15:0] w, inout logic erased);
    int unsigned at;
    at = fill_point();
    if (at >= PAGE_SLOTS) begin
      wipe_page();
      erased = 1'b1;
      at = 0;
    end
    page_img[at] = w;
  endfunction

  // Last stored mode; an out-of-range value is repaired by storing zero.
  function automatic logic [15:0] current_mode(inout logic erased, inout logic repaired);
    int unsigned at;
    logic [15:0] last;
    at = fill_point();
    if (at == 0) return fpal_pkg::ERASED_WORD;
    last = page_img[at - 1];
    if (last <= fpal_pkg::MODE_MAX) return last;
    store_word(16'd0, erased);
    repaired = 1'b1;
    return 16'd0;
  endfunction

  // Applies one operation to the page image and returns the result it should give.
  function automatic log_result_t predict_log_step(input fpal_pkg::op_t op,
                                                   input logic [15:0] word_data);
    log_result_t r;
    logic [15:0] cur;
    r = '0;
    case (op)
      fpal_pkg::OP_APPEND: begin
        store_word(word_data, r.erased);
        r.value = word_data;
      end
      fpal_pkg::OP_READ: begin
        r.value = current_mode(r.erased, r.repaired);
      end
      fpal_pkg::OP_CYCLE: begin
        cur = current_mode(r.erased, r.repaired);
        r.value = (cur == fpal_pkg::ERASED_WORD) ? 16'd0 : (cur + 16'd1) % 16'd3;
        store_word(r.value, r.erased);
      end
      default: begin
        r.value = 16'd0;
      end
    endcase
    r.used = 10'(fill_point());
    return r;
  endfunction

  // Compare outgoing words first, then predict the incoming one, so that a result
  // is never matched against a word taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_page();
      expected_results.delete();
      fails = 0;
      n_results = 0;
      n_erases = 0;
      n_repairs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[15:0], out_tdata[16], out_tdata[17], out_tdata[27:18]};
        n_results++;
        if (seen.erased) n_erases++;
        if (seen.repaired) n_repairs++;
        if (expected_results.size() == 0) begin
          $error("result word %h arrived with no operation outstanding", out_tdata);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (seen.value !== want.value) begin
            $error("value mismatch: expected %h, got %h", want.value, seen.value);
            fails++;
          end
          if (seen.erased !== want.erased) begin
            $error("page_erased mismatch: expected %b, got %b", want.erased, seen.erased);
            fails++;
          end
          if (seen.repaired !== want.repaired) begin
            $error("corrupt_repaired mismatch: expected %b, got %b",
                   want.repaired, seen.repaired);
            fails++;
          end
          if (seen.used !== want.used) begin
            $error("slots_used mismatch: expected %0d, got %0d", want.used, seen.used);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_log_step(fpal_pkg::op_t'(in_tuser), in_tdata));
    end
    fail_count   <= fails;
    pending      <= expected_results.size();
    results_seen <= n_results;
    erases_seen  <= n_erases;
    repairs_seen <= n_repairs;
  end

endmodule

>>> dv/flash_page_append_log_tb.sv
// Top of the flash page append log testbench: clock, reset, stimulus, receiver stalls and verdict.
module flash_page_append_log_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = fpal_pkg::PAGE_SLOTS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 640;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] data
  logic [1:0]  in_tuser;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] value, [16] page_erased,
                           // [17] corrupt_repaired, [27:18] slots_used
  int fail_count;
  int pending;
  int results_seen;
  int erases_seen;
  int repairs_seen;
  int burst_left;
  int words_sent;
  int idle_cycles;

  flash_page_append_log #(.PAGE_SLOTS(SLOTS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  flash_page_append_log_checker #(.PAGE_SLOTS(SLOTS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .erases_seen  (erases_seen),
    .repairs_seen (repairs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one word; bursts of random length are separated by random gaps.
  task automatic send_word(input fpal_pkg::op_t op, input logic [15:0] word_data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word_data;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Holds the input idle until every outstanding result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly ordinary halfwords, with valid modes and the erased pattern mixed in.
  function automatic logic [15:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'($urandom_range(0, 2));
    if (r == 2) return fpal_pkg::ERASED_WORD;
    if (r == 3) return 16'hFFFE;
    return 16'($urandom);
  endfunction

  function automatic fpal_pkg::op_t pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 62) return fpal_pkg::OP_APPEND;
    if (r < 80) return fpal_pkg::OP_READ;
    if (r < 96) return fpal_pkg::OP_CYCLE;
    return fpal_pkg::OP_NONE;
  endfunction

  // Receiver stalls: the pattern changes after a run of random length.
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned phase;
    out_tready <= 1'b0;
    mode = 0;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(64, 320);
      end
      left--;
      phase++;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((phase % 7) < 3);
      endcase
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_tvalid  <= 1'b0;
    in_tdata   <= 16'h0000;
    in_tuser   <= fpal_pkg::OP_NONE;
    rst_n      <= 1'b0;
    burst_left = 0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty page, the mode sequence, erased-pattern append, repairs,
    // the unused code and data extremes. The fill count reaches 16.
    send_word(fpal_pkg::OP_READ,   16'h0000);   // empty page reads as erased
    send_word(fpal_pkg::OP_CYCLE,  16'hFFFF);   // empty page cycles to mode 0
    send_word(fpal_pkg::OP_CYCLE,  16'h0000);
    send_word(fpal_pkg::OP_CYCLE,  16'h0000);
    send_word(fpal_pkg::OP_CYCLE,  16'h0000);   // wraps back to 0
    send_word(fpal_pkg::OP_APPEND, 16'hFFFF);   // slot stays erased
    send_word(fpal_pkg::OP_READ,   16'h0000);
    send_word(fpal_pkg::OP_APPEND, 16'h1234);
    send_word(fpal_pkg::OP_READ,   16'h0000);   // repairs the out-of-range value
    send_word(fpal_pkg::OP_APPEND, 16'hFFFE);
    send_word(fpal_pkg::OP_CYCLE,  16'h0000);   // repair, then advance to 1
    send_word(fpal_pkg::OP_NONE,   16'hFFFF);
    send_word(fpal_pkg::OP_APPEND, 16'h0000);
    send_word(fpal_pkg::OP_APPEND, 16'h5555);
    send_word(fpal_pkg::OP_APPEND, 16'hAAAA);
    send_word(fpal_pkg::OP_READ,   16'hFFFF);
    send_word(fpal_pkg::OP_APPEND, 16'h0002);
    send_word(fpal_pkg::OP_READ,   16'h0000);
    send_word(fpal_pkg::OP_NONE,   16'h0000);
    send_word(fpal_pkg::OP_APPEND, 16'h8000);
    send_word(fpal_pkg::OP_APPEND, 16'h7FFF);
    drain();

    // Fill the page with out-of-range data, then cycle: the repair needs an
    // erase before the new mode is stored.
    repeat (SLOTS - 16) send_word(fpal_pkg::OP_APPEND, 16'($urandom_range(3, 16'hFFFE)));
    send_word(fpal_pkg::OP_CYCLE, 16'h0000);

    // Random mix, weighted toward appends so the page wraps again.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain();
      send_word(pick_op(), pick_data());
    end

    drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d words over all four operation codes, including page fills and wraps.",
             words_sent);
    $display("Checked %0d results: %0d with a page erase, %0d with a repair.",
             results_seen, erases_seen, repairs_seen);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
